### rtl/cdq_pkg.sv
// Package for the circular deque: opcode and status codes, and the command
// that the top level broadcasts to every storage cell. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		OP_PUSH_HEAD = 2'd0,
		OP_PUSH_TAIL = 2'd1,
		OP_POP_HEAD  = 2'd2,
		OP_POP_TAIL  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE       = 2'd0,
		ST_FULL_PUSH  = 2'd1,
		ST_EMPTY_POP  = 2'd2,
		ST_UNUSED     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CMD_HOLD       = 3'd0,
		CMD_SHIFT_IN   = 3'd1,
		CMD_SHIFT_OUT  = 3'd2,
		CMD_APPEND     = 3'd3,
		CMD_TRIM       = 3'd4
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t   cmd;
		logic [DATA_W-1:0] push_data;
	} cell_ctl_t;

endpackage

`default_nettype wire

### rtl/circular_deque.sv
// Top level of the circular deque: command decode, the row of storage cells
// and the result register. Depends on cdq_pkg and cdq_cell.
`timescale 1ns / 1ps
`default_nettype none

// Double-ended queue of DEPTH 32-bit words held in a row of cells, the front
// entry always in cell 0. Each request is one operation (push front, push back,
// pop front, pop back) and yields one result with a status code, the popped word
// and the empty and full flags after the operation. A push into a full deque or
// a pop from an empty one is rejected and changes nothing. The whole row shifts
// or one cell loads or clears in the cycle of acceptance, and the result sits in
// an output register, so a new request is taken every cycle while results are
// taken. A pop back reads the last occupied cell through a one-hot select across
// the row.
module circular_deque
	import cdq_pkg::*;
#(
	parameter int unsigned DEPTH = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [1:0]  s_tuser,  // opcode[1:0]
	input  wire logic [31:0] s_tdata,  // data_in[31:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata   // status[1:0], data_out[33:2], is_empty[34],
	                                   // is_full[35], zero pad
);

	opcode_t           op;
	logic [DATA_W-1:0] din;
	logic              accept;
	cell_ctl_t         ctl;

	logic [DATA_W-1:0] cell_data  [DEPTH];
	logic [DEPTH-1:0]  cell_valid;
	logic [DEPTH-1:0]  cell_last;

	logic              now_empty;
	logic              now_full;
	status_t           status_n;
	logic [DATA_W-1:0] result_n;
	logic              empty_n;
	logic              full_n;
	logic [DATA_W-1:0] back_word;

	logic              out_valid_q;
	status_t           status_q;
	logic [DATA_W-1:0] result_q;
	logic              empty_q;
	logic              full_q;

	assign op     = opcode_t'(s_tuser);
	assign din    = s_tdata[DATA_W-1:0];
	assign accept = s_tvalid & s_tready;

	assign s_tready = ~out_valid_q | m_tready;

	assign now_empty = ~cell_valid[0];
	assign now_full  = cell_valid[DEPTH-1];

	always_comb begin
		back_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_word = back_word | (cell_data[i] & {DATA_W{cell_last[i]}});
		end
	end

	always_comb begin
		ctl.cmd       = CMD_HOLD;
		ctl.push_data = din;
		status_n      = ST_DONE;
		result_n      = '0;
		empty_n       = now_empty;
		full_n        = now_full;
		case (op)
			OP_PUSH_HEAD, OP_PUSH_TAIL: begin
				if (now_full) begin
					status_n = ST_FULL_PUSH;
				end else begin
					ctl.cmd = (op == OP_PUSH_HEAD) ? CMD_SHIFT_IN : CMD_APPEND;
					empty_n = 1'b0;
					full_n  = cell_valid[DEPTH-2];
				end
			end
			OP_POP_HEAD, OP_POP_TAIL: begin
				if (now_empty) begin
					status_n = ST_EMPTY_POP;
				end else begin
					ctl.cmd  = (op == OP_POP_HEAD) ? CMD_SHIFT_OUT : CMD_TRIM;
					result_n = (op == OP_POP_HEAD) ? cell_data[0] : back_word;
					empty_n  = ~cell_valid[1];
					full_n   = 1'b0;
				end
			end
			default: ctl.cmd = CMD_HOLD;
		endcase
		if (!accept) ctl.cmd = CMD_HOLD;
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [DATA_W-1:0] l_data;
		logic              l_valid;
		logic [DATA_W-1:0] r_data;
		logic              r_valid;

		if (g == 0) begin : g_first
			assign l_data  = din;
			assign l_valid = 1'b1;
		end else begin : g_mid_l
			assign l_data  = cell_data[g-1];
			assign l_valid = cell_valid[g-1];
		end

		if (g == DEPTH-1) begin : g_end
			assign r_data  = '0;
			assign r_valid = 1'b0;
		end else begin : g_mid_r
			assign r_data  = cell_data[g+1];
			assign r_valid = cell_valid[g+1];
		end

		cdq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.left_data   (l_data),
			.left_valid  (l_valid),
			.right_data  (r_data),
			.right_valid (r_valid),
			.data        (cell_data[g]),
			.valid       (cell_valid[g]),
			.is_last     (cell_last[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the result until the downstream side takes it.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_n;
			result_q <= result_n;
			empty_q  <= empty_n;
			full_q   <= full_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, full_q, empty_q, result_q, status_q};

endmodule

`default_nettype wire

### rtl/cdq_cell.sv
// One storage cell of the deque chain: a word and its occupied bit.
// Depends on cdq_pkg for the broadcast command.
`timescale 1ns / 1ps
`default_nettype none

module cdq_cell
	import cdq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cell_ctl_t         ctl,
	input  wire logic [DATA_W-1:0] left_data,
	input  wire logic              left_valid,
	input  wire logic [DATA_W-1:0] right_data,
	input  wire logic              right_valid,
	output logic      [DATA_W-1:0] data,
	output logic                   valid,
	output logic                   is_last
);

	logic [DATA_W-1:0] data_q;
	logic              valid_q;

	assign data    = data_q;
	assign valid   = valid_q;
	assign is_last = valid_q & ~right_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctl.cmd)
				CMD_SHIFT_IN:  valid_q <= left_valid;
				CMD_SHIFT_OUT: valid_q <= right_valid;
				CMD_APPEND: begin
					if (left_valid && !valid_q) valid_q <= 1'b1;
				end
				CMD_TRIM: begin
					if (is_last) valid_q <= 1'b0;
				end
				default: valid_q <= valid_q;
			endcase
		end
	end

	// Move words toward the back on a front push, toward the front on a front pop; load the pushed word on a back push.
	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_SHIFT_IN:  data_q <= left_data;
			CMD_SHIFT_OUT: data_q <= right_data;
			CMD_APPEND: begin
				if (left_valid && !valid_q) data_q <= ctl.push_data;
			end
			default: data_q <= data_q;
		endcase
	end

endmodule

`default_nettype wire
